@@ rtl/two_digit_seven_segment_scanner_macros.svh @@
// Assertion macros for the two-digit seven-segment scanner.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef TWO_DIGIT_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define TDSS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset
`define TDSS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);
`else
`define TDSS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg)
`define TDSS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

@@ rtl/tdss_pkg.sv @@
// Shared types, codes and decode functions for the two-digit scanner.
// No dependencies.
`default_nettype none
package tdss_pkg;

    // Item kinds carried in the input tuser
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_CHAR  = 2'd1,
        MODE_PRINT = 2'd2,
        MODE_POINT = 2'd3
    } mode_t;

    // Register byte addresses
    localparam logic [2:0] ADDR_REFRESH_INTERVAL = 3'd0;

    localparam logic [15:0] REFRESH_INTERVAL_RESET = 16'd1;
    localparam logic [15:0] TICKS_MAX              = 16'hFFFF;
    localparam logic [7:0]  CHAR_RESET             = 8'd51;   // '3'
    localparam logic [7:0]  CHAR_ZERO              = 8'd48;   // '0'
    localparam logic [7:0]  CHAR_A                 = 8'd65;   // 'A'
    localparam logic [7:0]  CHAR_HEX_BASE          = 8'd55;   // 'A' - 10
    localparam logic [9:0]  NUMBER_MAX             = 10'd999;
    localparam int          PATTERN_COUNT          = 17;

    // Segment patterns, bit0 = a ... bit6 = g; last entry is blank
    localparam logic [6:0] SEG_PATTERNS [PATTERN_COUNT] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67,
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h00
    };

    typedef struct packed {
        mode_t       mode;
        logic        digit_index;
        logic [7:0]  character;
        logic [9:0]  number;
        logic        dp_on;
    } item_t;

    typedef struct packed {
        logic       refreshed;
        logic       decimal_point;
        logic [1:0] digit_enable;
        logic [6:0] segments;
    } result_t;

    // Pattern index of a character; 8-bit wrap below '0' pushes it out of range
    function automatic logic [7:0] char_index(input logic [7:0] c);
        if (c >= CHAR_A) begin
            return c - CHAR_HEX_BASE;
        end
        return c - CHAR_ZERO;
    endfunction

    // Quotient by ten for values up to 999: multiply by 205, shift by 11
    function automatic logic [6:0] div10(input logic [9:0] n);
        logic [17:0] prod;
        prod = 18'(n) * 18'd205;
        return prod[17:11];
    endfunction

endpackage
`default_nettype wire

@@ rtl/tdss_apb_regs.sv @@
// APB register block holding refresh_interval.
// Depends on tdss_pkg.
`default_nettype none
module tdss_apb_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [15:0]      refresh_interval
);
    logic [15:0] interval_reg;
    logic [15:0] interval_next;
    logic        wr_hit;

    assign pready = 1'b1;
    // Register 0 covers byte addresses 0..3
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr[2] == tdss_pkg::ADDR_REFRESH_INTERVAL[2]);

    always_comb begin
        interval_next = interval_reg;
        if (wr_hit) begin
            interval_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= tdss_pkg::REFRESH_INTERVAL_RESET;
        end else begin
            interval_reg <= interval_next;
        end
    end

    // Read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == tdss_pkg::ADDR_REFRESH_INTERVAL[2]) begin
            prdata = {16'd0, interval_reg};
        end
    end

    assign refresh_interval = interval_reg;
endmodule
`default_nettype wire

@@ rtl/tdss_core.sv @@
// Scanner state and per-word update logic: tick counter, digit stores, drive latches.
// Depends on tdss_pkg.
`default_nettype none
module tdss_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire tdss_pkg::item_t  item,
    input  wire logic [15:0]      refresh_interval,
    output tdss_pkg::result_t     result
);
    logic [15:0] ticks_reg, ticks_next;
    logic        active_reg, active_next;
    logic [7:0]  char_reg [2];
    logic [7:0]  char_next [2];
    logic        point_reg [2];
    logic        point_next [2];
    logic [6:0]  seg_reg, seg_next;
    logic [1:0]  enable_reg, enable_next;
    logic        dp_reg, dp_next;
    logic        refresh;

    logic [15:0] ticks_inc;
    logic [9:0]  num_sat;
    logic [6:0]  tens;
    logic [9:0]  tens_x10;
    logic [3:0]  ones;
    logic [7:0]  pat_idx;

    // Number split for printing
    always_comb begin
        num_sat  = (item.number > tdss_pkg::NUMBER_MAX) ? tdss_pkg::NUMBER_MAX : item.number;
        tens     = tdss_pkg::div10(num_sat);
        tens_x10 = {tens, 3'd0} + {2'd0, tens, 1'd0};
        ones     = 4'(num_sat - tens_x10);
    end

    assign ticks_inc = (ticks_reg < tdss_pkg::TICKS_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    assign pat_idx   = tdss_pkg::char_index(char_reg[~active_reg]);

    // Next state for one word
    always_comb begin
        ticks_next  = ticks_reg;
        active_next = active_reg;
        char_next   = char_reg;
        point_next  = point_reg;
        seg_next    = seg_reg;
        enable_next = enable_reg;
        dp_next     = dp_reg;
        refresh     = 1'b0;
        case (item.mode)
            tdss_pkg::MODE_TICK: begin
                ticks_next = ticks_inc;
                if (ticks_inc > refresh_interval) begin
                    refresh     = 1'b1;
                    ticks_next  = 16'd0;
                    active_next = ~active_reg;
                    enable_next = active_reg ? 2'b01 : 2'b10;
                    dp_next     = point_reg[~active_reg];
                    if (pat_idx < 8'(tdss_pkg::PATTERN_COUNT)) begin
                        seg_next = tdss_pkg::SEG_PATTERNS[pat_idx[4:0]];
                    end
                end
            end
            tdss_pkg::MODE_CHAR: begin
                char_next[item.digit_index] = item.character;
            end
            tdss_pkg::MODE_PRINT: begin
                char_next[1] = tdss_pkg::CHAR_ZERO + {4'd0, ones};
                if (num_sat < 10'd10) begin
                    char_next[0] = tdss_pkg::CHAR_ZERO;
                end else if (num_sat < 10'd100) begin
                    char_next[0] = tdss_pkg::CHAR_ZERO + {1'b0, tens};
                end else begin
                    char_next[0] = tdss_pkg::CHAR_HEX_BASE + {1'b0, tens};
                end
            end
            tdss_pkg::MODE_POINT: begin
                point_next[item.digit_index] = item.dp_on;
            end
            default: begin
                ticks_next = ticks_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg  <= 16'd0;
            active_reg <= 1'b0;
            char_reg   <= '{tdss_pkg::CHAR_RESET, tdss_pkg::CHAR_RESET};
            point_reg  <= '{1'b0, 1'b0};
            seg_reg    <= 7'd0;
            enable_reg <= 2'd0;
            dp_reg     <= 1'b0;
        end else if (advance) begin
            ticks_reg  <= ticks_next;
            active_reg <= active_next;
            char_reg   <= char_next;
            point_reg  <= point_next;
            seg_reg    <= seg_next;
            enable_reg <= enable_next;
            dp_reg     <= dp_next;
        end
    end

    // Result word as the latches stand after this word
    always_comb begin
        result.segments      = seg_next;
        result.digit_enable  = enable_next;
        result.decimal_point = dp_next;
        result.refreshed     = refresh;
    end
endmodule
`default_nettype wire

@@ rtl/two_digit_seven_segment_scanner.sv @@
// Two-digit seven-segment scanner: input register, update logic, result register.
// A word accepted passes the input register and the update logic into the result register on m_.
// One word per cycle unless m_ stalls, set by the single update stage and the result register.
// Reset (aresetn low, synchronous): both pipeline slots empty, digits hold '3',
// points off, counter and drive latches zero, refresh_interval back to 1.
// Depends on tdss_pkg, tdss_apb_regs, tdss_core and the macro header.
`default_nettype none
`include "two_digit_seven_segment_scanner_macros.svh"
module two_digit_seven_segment_scanner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // digit_index[0], character[8:1], number[18:9], dp_on[19]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // segments[6:0], digit_enable[8:7], decimal_point[9],
                                        // refreshed[10]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic              in_valid_reg;
    tdss_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    tdss_pkg::result_t out_reg;
    tdss_pkg::result_t result;
    logic              advance;
    logic [15:0]       refresh_interval;

    tdss_apb_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .refresh_interval (refresh_interval)
    );

    // Stage moves when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.mode        <= tdss_pkg::mode_t'(s_tuser);
            in_item_reg.digit_index <= s_tdata[0];
            in_item_reg.character   <= s_tdata[8:1];
            in_item_reg.number      <= s_tdata[18:9];
            in_item_reg.dp_on       <= s_tdata[19];
        end
    end

    tdss_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .item             (in_item_reg),
        .refresh_interval (refresh_interval),
        .result           (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.refreshed, out_reg.decimal_point,
                       out_reg.digit_enable, out_reg.segments};

    // Checks
    `TDSS_ASSERT_IMPLIES(a_refresh_onehot, aclk, aresetn, m_tvalid && m_tdata[10],
        $onehot(m_tdata[8:7]), "refresh word without one-hot digit enable")
    `TDSS_ASSERT_IMPLIES(a_stall_has_word, aclk, aresetn, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled without a blocked word")
    `TDSS_ASSERT_NEXT(a_result_held, aclk, aresetn, out_valid_reg && !m_tready,
        out_valid_reg, "pending result word dropped")
endmodule
`default_nettype wire
